@@ hdl/rotozoom_texture_mapper_macros.svh @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper assertion macros
// Shared concurrent assertion forms for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef ROTOZOOM_TEXTURE_MAPPER_MACROS_SVH
`define ROTOZOOM_TEXTURE_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while the reset argument is low.
`define RTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rotozoom_texture_mapper: assertion failed");

// Next-cycle implication, disabled while the reset argument is low.
`define RTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rotozoom_texture_mapper: assertion failed");

`endif

@@ hdl/rtm_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper package
// Shared types and constants of the front end, command queue and back end.
// ----------------------------------------------------------------------------
package rtm_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int SINE_ENTRIES  = 256;
    localparam int TEX_DEPTH     = 65536;

    localparam logic [8:0] COL_LAST = 9'(SCREEN_WIDTH - 1);
    localparam logic [7:0] ROW_LAST = 8'(SCREEN_HEIGHT - 1);

    localparam logic [7:0] COS_OFFSET   = 8'd64;
    localparam logic [9:0] RECIP3       = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_TEXEL = 2'd0,
        KIND_SINE  = 2'd1,
        KIND_FRAME = 2'd2,
        KIND_PIXEL = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FRM_LO,
        ST_FRM_HI
    } t_back_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] tex_addr;
        logic [7:0]  tex_value;
        logic [7:0]  sine_idx;
        logic [8:0]  sine_value;
        logic [7:0]  u_idx;
        logic [7:0]  v_idx;
        logic [7:0]  sin_idx;
        logic [7:0]  cos_idx;
    } t_cmd;

    typedef struct packed {
        logic [7:0] colour;
        logic [8:0] column;
        logic [7:0] row;
        logic       row_end;
        logic       frame_end;
    } t_pix;

endpackage

@@ hdl/rotozoom_texture_mapper.sv @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper
// Rotating and zooming affine texture mapper with a 256 by 256 texture.
// ----------------------------------------------------------------------------
// Input transactions carry a kind: load a texel, load a sine table entry,
// start a frame, or request the next pixel. Only a pixel request gives an
// output transaction: the texel colour, the screen position and the row and
// frame end flags. Results leave in the order of their requests.
// One transaction is accepted per cycle when nothing stalls. A pixel result
// passes through the command queue, the texture read register and the
// result buffer before it is valid. A frame start holds the back end in the
// states ST_FRM_LO and ST_FRM_HI while its four sine reads run in pairs
// over the dual read port.
// Loads do not hold the back end.
// After reset all accumulators, steps and counts are zero and both queues
// are empty; the texture and the sine table hold nothing defined until they
// are loaded. When the receiver stalls, two results wait in the output
// buffer, then four transactions in the command queue, and only then does
// the input ready fall.
// ----------------------------------------------------------------------------
module rotozoom_texture_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_texel_address,
    input  logic [7:0]  i_texel_value,
    input  logic [7:0]  i_sine_index,
    input  logic [8:0]  i_sine_value,
    input  logic [30:0] i_frame_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_colour,
    output logic [8:0]  o_pixel_column,
    output logic [7:0]  o_pixel_row,
    output logic        o_row_end,
    output logic        o_frame_end
);
    import rtm_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push_valid;
    logic push_ready;
    logic pop_valid;
    logic pop_ready;

    rtm_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .i_sine_index    (i_sine_index),
        .i_sine_value    (i_sine_value),
        .i_frame_number  (i_frame_number),
        .o_push_valid    (push_valid),
        .i_push_ready    (push_ready),
        .o_cmd           (front_cmd)
    );

    rtm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_cmd        (front_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_cmd        (queue_cmd)
    );

    rtm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (pop_valid),
        .o_cmd_ready    (pop_ready),
        .i_cmd          (queue_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_colour       (o_colour),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end)
    );

endmodule

@@ hdl/rtm_front.sv @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper front end
// Classifies input transactions and derives the four sine table positions of
// a frame start from its number.
// ----------------------------------------------------------------------------
module rtm_front (
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_kind,
    input  logic [15:0]   i_texel_address,
    input  logic [7:0]    i_texel_value,
    input  logic [7:0]    i_sine_index,
    input  logic [8:0]    i_sine_value,
    input  logic [30:0]   i_frame_number,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output rtm_pkg::t_cmd o_cmd
);
    import rtm_pkg::*;

    logic [23:0] hi;
    logic [4:0]  sum_a;
    logic [4:0]  sum_b;
    logic [5:0]  sum_all;
    logic [3:0]  fold;
    logic [1:0]  hi_mod3;
    logic [9:0]  rem768;
    logic [19:0] prod;

    function automatic logic [1:0] mod3_small(input logic [3:0] v);
        logic [1:0] r;
        case (v)
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    // The quotient by three modulo 256 depends only on the number modulo 768.
    always_comb begin
        hi    = {1'b0, i_frame_number[30:8]};
        sum_a = '0;
        sum_b = '0;
        for (int k = 0; k < 6; k++) begin
            sum_a = sum_a + 5'(hi[2*k +: 2]);
            sum_b = sum_b + 5'(hi[2*k+12 +: 2]);
        end
        sum_all = 6'(sum_a) + 6'(sum_b);
        fold    = 4'(sum_all[1:0]) + 4'(sum_all[3:2]) + 4'(sum_all[5:4]);
        hi_mod3 = mod3_small(fold);
        rem768  = {hi_mod3, i_frame_number[7:0]};
        prod    = 20'(rem768) * 20'(RECIP3);
    end

    always_comb begin
        o_cmd.kind       = t_kind'(i_kind);
        o_cmd.tex_addr   = i_texel_address;
        o_cmd.tex_value  = i_texel_value;
        o_cmd.sine_idx   = i_sine_index;
        o_cmd.sine_value = i_sine_value;
        o_cmd.u_idx      = i_frame_number[8:1];
        o_cmd.v_idx      = prod[RECIP3_SHIFT +: 8];
        o_cmd.sin_idx    = i_frame_number[7:0];
        o_cmd.cos_idx    = i_frame_number[7:0] + COS_OFFSET;
    end

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

endmodule

@@ hdl/rtm_queue.sv @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rtm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  rtm_pkg::t_cmd i_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output rtm_pkg::t_cmd o_cmd
);
    import rtm_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wp;
    logic [QPTR_W-1:0] n_rp;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_cmd        = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
    assign n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= n_wp;
            end
            if (pop) begin
                r_rp <= n_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/rtm_back.sv @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper back end
// Holds the texture and sine stores, loads frames, steps the accumulators and
// buffers finished pixels for the output channel.
// ----------------------------------------------------------------------------
module rtm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  rtm_pkg::t_cmd i_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_colour,
    output logic [8:0]    o_pixel_column,
    output logic [7:0]    o_pixel_row,
    output logic          o_row_end,
    output logic          o_frame_end
);
    import rtm_pkg::*;

    logic [7:0]  r_tex  [TEX_DEPTH];
    logic [8:0]  r_sine [SINE_ENTRIES];
    logic [7:0]  r_tex_q;
    logic [8:0]  r_sine_qa;
    logic [8:0]  r_sine_qb;

    t_back_state r_state;
    t_back_state n_state;

    logic [7:0]  r_sin_idx;
    logic [7:0]  r_cos_idx;
    logic [15:0] r_frame_u;
    logic [15:0] r_frame_v;
    logic [15:0] r_row_u;
    logic [15:0] r_row_v;
    logic [15:0] r_pix_u;
    logic [15:0] r_pix_v;
    logic [8:0]  r_step_sin;
    logic [8:0]  r_step_cos;
    logic [8:0]  r_col;
    logic [7:0]  r_row;

    logic        r_rd_valid;
    t_pix        r_rd_meta;
    t_pix        rd_pix;

    t_pix        r_ob [OUT_DEPTH];
    logic        r_ob_wp;
    logic        r_ob_rp;
    logic [1:0]  r_ob_cnt;

    logic        tex_we;
    logic        sine_we;
    logic        frm_start;
    logic        frm_lo;
    logic        frm_hi;
    logic        pix_go;
    logic [7:0]  sine_ra;
    logic [7:0]  sine_rb;
    logic        ob_pop;
    logic [2:0]  pend;
    logic        issue_ok;
    logic        row_end;
    logic        frame_end;

    assign ob_pop    = (r_ob_cnt != 2'd0) && i_out_ready;
    assign pend      = 3'(r_ob_cnt) + 3'(r_rd_valid);
    assign issue_ok  = (pend < 3'(OUT_DEPTH)) || ob_pop;
    assign row_end   = (r_col >= COL_LAST);
    assign frame_end = row_end && (r_row >= ROW_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        tex_we      = 1'b0;
        sine_we     = 1'b0;
        frm_start   = 1'b0;
        frm_lo      = 1'b0;
        frm_hi      = 1'b0;
        pix_go      = 1'b0;
        sine_ra     = i_cmd.u_idx;
        sine_rb     = i_cmd.v_idx;
        case (r_state)
            ST_RUN: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        KIND_TEXEL: begin
                            o_cmd_ready = 1'b1;
                            tex_we      = 1'b1;
                        end
                        KIND_SINE: begin
                            o_cmd_ready = 1'b1;
                            sine_we     = 1'b1;
                        end
                        KIND_FRAME: begin
                            o_cmd_ready = 1'b1;
                            frm_start   = 1'b1;
                            n_state     = ST_FRM_LO;
                        end
                        KIND_PIXEL: begin
                            o_cmd_ready = issue_ok;
                            pix_go      = issue_ok;
                        end
                        default: begin
                            o_cmd_ready = 1'b0;
                        end
                    endcase
                end
            end
            ST_FRM_LO: begin
                frm_lo  = 1'b1;
                sine_ra = r_sin_idx;
                sine_rb = r_cos_idx;
                n_state = ST_FRM_HI;
            end
            ST_FRM_HI: begin
                frm_hi  = 1'b1;
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tex_we) begin
            r_tex[i_cmd.tex_addr] <= i_cmd.tex_value;
        end
        r_tex_q <= r_tex[{r_pix_v[15:8], r_pix_u[15:8]}];
    end

    always_ff @(posedge i_clk) begin
        if (sine_we) begin
            r_sine[i_cmd.sine_idx] <= i_cmd.sine_value;
        end
        r_sine_qa <= r_sine[sine_ra];
        r_sine_qb <= r_sine[sine_rb];
    end

    always_comb begin
        rd_pix        = r_rd_meta;
        rd_pix.colour = r_tex_q;
    end

    always_ff @(posedge i_clk) begin
        if (frm_start) begin
            r_sin_idx <= i_cmd.sin_idx;
            r_cos_idx <= i_cmd.cos_idx;
        end
        if (pix_go) begin
            r_rd_meta.colour    <= '0;
            r_rd_meta.column    <= r_col;
            r_rd_meta.row       <= r_row;
            r_rd_meta.row_end   <= row_end;
            r_rd_meta.frame_end <= frame_end;
        end
        if (r_rd_valid) begin
            r_ob[r_ob_wp] <= rd_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_u  <= '0;
            r_frame_v  <= '0;
            r_row_u    <= '0;
            r_row_v    <= '0;
            r_pix_u    <= '0;
            r_pix_v    <= '0;
            r_step_sin <= '0;
            r_step_cos <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (frm_lo) begin
                r_frame_u <= {r_sine_qa[7:0], 8'h00};
                r_frame_v <= {r_sine_qb[7:0], 8'h00};
            end
            if (frm_hi) begin
                r_step_sin <= r_sine_qa;
                r_step_cos <= r_sine_qb;
                r_row_u    <= r_frame_u;
                r_row_v    <= r_frame_v;
                r_pix_u    <= r_frame_u;
                r_pix_v    <= r_frame_v;
                r_col      <= '0;
                r_row      <= '0;
            end else if (pix_go) begin
                if (frame_end) begin
                    r_row_u <= r_frame_u;
                    r_row_v <= r_frame_v;
                    r_pix_u <= r_frame_u;
                    r_pix_v <= r_frame_v;
                    r_col   <= '0;
                    r_row   <= '0;
                end else if (row_end) begin
                    r_row_u <= r_row_u - 16'(r_step_sin);
                    r_row_v <= r_row_v + 16'(r_step_cos);
                    r_pix_u <= r_row_u - 16'(r_step_sin);
                    r_pix_v <= r_row_v + 16'(r_step_cos);
                    r_col   <= '0;
                    r_row   <= r_row + 8'd1;
                end else begin
                    r_pix_u <= r_pix_u + 16'(r_step_cos);
                    r_pix_v <= r_pix_v + 16'(r_step_sin);
                    r_col   <= r_col + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_ob_wp    <= 1'b0;
            r_ob_rp    <= 1'b0;
            r_ob_cnt   <= '0;
        end else begin
            r_rd_valid <= pix_go;
            if (r_rd_valid) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            case ({r_rd_valid, ob_pop})
                2'b10:   r_ob_cnt <= r_ob_cnt + 2'd1;
                2'b01:   r_ob_cnt <= r_ob_cnt - 2'd1;
                default: r_ob_cnt <= r_ob_cnt;
            endcase
        end
    end

    assign o_out_valid    = (r_ob_cnt != 2'd0);
    assign o_colour       = r_ob[r_ob_rp].colour;
    assign o_pixel_column = r_ob[r_ob_rp].column;
    assign o_pixel_row    = r_ob[r_ob_rp].row;
    assign o_row_end      = r_ob[r_ob_rp].row_end;
    assign o_frame_end    = r_ob[r_ob_rp].frame_end;

endmodule

@@ hdl/rtm_checker.sv @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper checker
// Watches the output channel of the block and is bound to its top level.
// ----------------------------------------------------------------------------
`include "rotozoom_texture_mapper_macros.svh"

module rtm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_colour,
    input logic [8:0] i_pixel_column,
    input logic [7:0] i_pixel_row,
    input logic       i_row_end,
    input logic       i_frame_end
);
    import rtm_pkg::*;

    `RTM_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_colour) && $stable(i_pixel_column) && $stable(i_pixel_row) && $stable(i_row_end) && $stable(i_frame_end))
    `RTM_ASSERT_IMP(a_row_end, i_clk, i_rst_n, i_out_valid, i_row_end == (i_pixel_column == COL_LAST))
    `RTM_ASSERT_IMP(a_frame_end, i_clk, i_rst_n, i_out_valid, i_frame_end == (i_row_end && (i_pixel_row == ROW_LAST)))
    `RTM_ASSERT_NXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid)

endmodule

bind rotozoom_texture_mapper rtm_checker u_rtm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_colour       (o_colour),
    .i_pixel_column (o_pixel_column),
    .i_pixel_row    (o_pixel_row),
    .i_row_end      (o_row_end),
    .i_frame_end    (o_frame_end)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Rotozoom texture mapper testbench
// Builds directed and random transactions together with the pixels they are
// expected to give, loading every texel and sine entry before it is read,
// and compares every pixel result in order, including a row crossing.
// ----------------------------------------------------------------------------
module tb;

    import rtm_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int ITEM_TARGET = 600;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        t_kind       kind;
        logic [15:0] texel_address;
        logic [7:0]  texel_value;
        logic [7:0]  sine_index;
        logic [8:0]  sine_value;
        logic [30:0] frame_number;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [15:0] i_texel_address;
    logic [7:0]  i_texel_value;
    logic [7:0]  i_sine_index;
    logic [8:0]  i_sine_value;
    logic [30:0] i_frame_number;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_colour;
    logic [8:0]  o_pixel_column;
    logic [7:0]  o_pixel_row;
    logic        o_row_end;
    logic        o_frame_end;

    t_request queued_requests[$];
    t_pix     expected_pixels[$];

    logic [7:0]  texture_mem [0:TEX_DEPTH-1];
    logic [8:0]  sine_mem [0:SINE_ENTRIES-1];
    bit          tex_written [0:TEX_DEPTH-1];
    bit          sine_written [0:SINE_ENTRIES-1];
    logic [15:0] pix_u        = '0;
    logic [15:0] pix_v        = '0;
    logic [15:0] line_u       = '0;
    logic [15:0] line_v       = '0;
    logic [15:0] start_u      = '0;
    logic [15:0] start_v      = '0;
    logic [8:0]  step_cos     = '0;
    logic [8:0]  step_sin     = '0;
    logic [8:0]  column_count = '0;
    logic [7:0]  row_count    = '0;

    logic in_taken       = 1'b0;
    int   sent_count     = 0;
    int   received_count = 0;
    int   error_count    = 0;
    int   quiet_cycles   = 0;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;

    rotozoom_texture_mapper u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .i_sine_index    (i_sine_index),
        .i_sine_value    (i_sine_value),
        .i_frame_number  (i_frame_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_colour        (o_colour),
        .o_pixel_column  (o_pixel_column),
        .o_pixel_row     (o_pixel_row),
        .o_row_end       (o_row_end),
        .o_frame_end     (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_request noise_request(input t_kind kind);
        t_request r;
        r.kind          = kind;
        r.texel_address = 16'($urandom);
        r.texel_value   = 8'($urandom);
        r.sine_index    = 8'($urandom);
        r.sine_value    = 9'($urandom);
        r.frame_number  = 31'($urandom);
        return r;
    endfunction

    task automatic map_transaction(input t_request r);
        logic [30:0] third;
        logic [30:0] half;
        logic [7:0]  cos_index;
        t_pix        px;
        third     = r.frame_number / 31'd3;
        half      = r.frame_number / 31'd2;
        cos_index = r.frame_number[7:0] + COS_OFFSET;
        case (r.kind)
            KIND_TEXEL: texture_mem[r.texel_address] = r.texel_value;
            KIND_SINE:  sine_mem[r.sine_index] = r.sine_value;
            KIND_FRAME: begin
                start_v      = {sine_mem[third[7:0]][7:0], 8'h00};
                start_u      = {sine_mem[half[7:0]][7:0], 8'h00};
                step_sin     = sine_mem[r.frame_number[7:0]];
                step_cos     = sine_mem[cos_index];
                line_u       = start_u;
                line_v       = start_v;
                pix_u        = start_u;
                pix_v        = start_v;
                column_count = '0;
                row_count    = '0;
            end
            KIND_PIXEL: begin
                px.colour    = texture_mem[{pix_v[15:8], pix_u[15:8]}];
                px.column    = column_count;
                px.row       = row_count;
                px.row_end   = (column_count >= COL_LAST);
                px.frame_end = px.row_end && (row_count >= ROW_LAST);
                expected_pixels.push_back(px);
                if (px.frame_end) begin
                    line_u       = start_u;
                    line_v       = start_v;
                    pix_u        = start_u;
                    pix_v        = start_v;
                    column_count = '0;
                    row_count    = '0;
                end else if (px.row_end) begin
                    line_u       = line_u - {7'b0, step_sin};
                    line_v       = line_v + {7'b0, step_cos};
                    pix_u        = line_u;
                    pix_v        = line_v;
                    column_count = '0;
                    row_count    = row_count + 8'd1;
                end else begin
                    pix_u        = pix_u + {7'b0, step_cos};
                    pix_v        = pix_v + {7'b0, step_sin};
                    column_count = column_count + 9'd1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_request(input t_request r);
        if (r.kind == KIND_TEXEL) tex_written[r.texel_address] = 1'b1;
        if (r.kind == KIND_SINE) sine_written[r.sine_index] = 1'b1;
        map_transaction(r);
        queued_requests.push_back(r);
    endtask

    task automatic queue_texel(input logic [15:0] address, input logic [7:0] value);
        t_request r;
        r = noise_request(KIND_TEXEL);
        r.texel_address = address;
        r.texel_value   = value;
        queue_request(r);
    endtask

    task automatic queue_sine(input logic [7:0] index, input logic [8:0] value);
        t_request r;
        r = noise_request(KIND_SINE);
        r.sine_index = index;
        r.sine_value = value;
        queue_request(r);
    endtask

    task automatic queue_sine_if_unset(input logic [7:0] index);
        if (!sine_written[index]) queue_sine(index, 9'($urandom));
    endtask

    // A frame start reads four sine entries, so each is loaded first if need be.
    task automatic queue_frame(input logic [30:0] number);
        t_request    r;
        logic [30:0] third;
        logic [30:0] half;
        third = number / 31'd3;
        half  = number / 31'd2;
        queue_sine_if_unset(third[7:0]);
        queue_sine_if_unset(half[7:0]);
        queue_sine_if_unset(number[7:0]);
        queue_sine_if_unset(number[7:0] + COS_OFFSET);
        r = noise_request(KIND_FRAME);
        r.frame_number = number;
        queue_request(r);
    endtask

    task automatic queue_pixel();
        logic [15:0] address;
        address = {pix_v[15:8], pix_u[15:8]};
        if (!tex_written[address]) queue_texel(address, 8'($urandom));
        queue_request(noise_request(KIND_PIXEL));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin : drive_requests
        t_request item;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (queued_requests.size() > 0 &&
                ((sent_count >= 100 && sent_count < 250) || $urandom_range(0, 99) >= 21)) begin
                item = queued_requests.pop_front();
                i_kind          <= item.kind;
                i_texel_address <= item.texel_address;
                i_texel_value   <= item.texel_value;
                i_sine_index    <= item.sine_index;
                i_sine_value    <= item.sine_value;
                i_frame_number  <= item.frame_number;
                i_in_valid      <= 1'b1;
                sent_count      <= sent_count + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && received_count >= 40) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (received_count >= 150 && received_count < 300) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 21);
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_pix want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                received_count <= received_count + 1;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel transaction, expected none, actual column %0d row %0d",
                             $time, o_pixel_column, o_pixel_row);
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("colour", want.colour, o_colour);
                    check_field("pixel_column", want.column, o_pixel_column);
                    check_field("pixel_row", want.row, o_pixel_row);
                    check_field("row_end", want.row_end, o_row_end);
                    check_field("frame_end", want.frame_end, o_frame_end);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int pick;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_kind          = KIND_TEXEL;
        i_texel_address = '0;
        i_texel_value   = '0;
        i_sine_index    = '0;
        i_sine_value    = '0;
        i_frame_number  = '0;
        i_out_ready     = 1'b0;

        // Pixels before any frame start use the all-zero reset state.
        repeat (3) queue_pixel();
        queue_texel(16'h0000, 8'hFF);
        queue_texel(16'hFFFF, 8'h00);
        queue_sine(8'd0, 9'h000);
        queue_sine(8'd64, 9'h1FF);
        queue_sine(8'd255, 9'h1FF);
        queue_frame(31'd0);
        repeat (3) queue_pixel();
        queue_frame(31'h7FFF_FFFF);
        repeat (3) queue_pixel();
        queue_frame(31'd250);
        repeat (2) queue_pixel();

        // Small steps keep the texels of a full row and its successor few.
        queue_sine(8'd150, 9'h1F0);
        queue_sine(8'd100, 9'h0E0);
        queue_sine(8'd44, 9'd21);
        queue_sine(8'd108, 9'd37);
        queue_frame(31'd300);
        repeat (SCREEN_WIDTH + 10) queue_pixel();

        while (queued_requests.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) queue_request(noise_request(KIND_TEXEL));
            else if (pick < 20) queue_request(noise_request(KIND_SINE));
            else if (pick < 26) queue_frame(31'($urandom));
            else queue_pixel();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_requests.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_pixels.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
